[rtl/bglq_pkg.sv]
// Shared types, widths, codes and helpers for the bitmap glyph quad layout block.
// Used by bglq_div, bglq_emit and bitmap_glyph_quad_layout; depends on nothing.
package bglq_pkg;

   localparam int CURSOR_BITS   = 12;
   localparam int FRAC_BITS     = 8;
   localparam int ATLAS_COLUMNS = 16;
   localparam int ATLAS_BITS    = $clog2(ATLAS_COLUMNS);

   localparam int CODE_BITS = 21;
   localparam int REG_BITS  = 8;
   localparam int X_BITS    = 40;
   localparam int Y_BITS    = 31;
   localparam int U_BITS    = 12;
   localparam int V_BITS    = 26;

   localparam int DIV_BITS    = 2 * REG_BITS + FRAC_BITS;
   localparam int MUL_A_BITS  = DIV_BITS;
   localparam int MUL_B_BITS  = CODE_BITS - ATLAS_BITS;
   localparam int PROD_BITS   = MUL_A_BITS + MUL_B_BITS;
   localparam int SUM_BITS    = ((CURSOR_BITS > REG_BITS) ? CURSOR_BITS : REG_BITS) + 1;

   localparam int REQ_DATA_BITS = ((CODE_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = X_BITS + Y_BITS + U_BITS + V_BITS;
   localparam int RSP_DATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CURSOR_BITS-1:0] CURSOR_MAX = '1;

   localparam logic [CSR_INDEX_BITS-1:0] REG_GLYPH_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GLYPH_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CAP_TOP      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CHAR_SIZE    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TAB_SIZE     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FILL_COLOR   = 3'd5;

   localparam logic [CODE_BITS-1:0] CHAR_TAB     = 21'd9;
   localparam logic [CODE_BITS-1:0] CHAR_NEWLINE = 21'd10;
   localparam logic [CODE_BITS-1:0] CHAR_VTAB    = 21'd11;
   localparam logic [CODE_BITS-1:0] CHAR_RETURN  = 21'd13;
   localparam logic [CODE_BITS-1:0] CHAR_SPACE   = 21'd32;

   typedef enum logic [1:0] {
      CORNER_TL = 2'd0,
      CORNER_TR = 2'd1,
      CORNER_BR = 2'd2,
      CORNER_BL = 2'd3
   } corner_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef struct packed {
      logic [X_BITS-1:0] x1;
      logic [X_BITS-1:0] x2;
      logic [Y_BITS-1:0] y1;
      logic [Y_BITS-1:0] y2;
      logic [U_BITS-1:0] u1;
      logic [U_BITS-1:0] u2;
      logic [V_BITS-1:0] v1;
      logic [V_BITS-1:0] v2;
   } vertex_set_type;

   function automatic logic [CURSOR_BITS-1:0] sat_add(input logic [CURSOR_BITS-1:0] a,
                                                     input logic [REG_BITS-1:0] b);
      logic [SUM_BITS-1:0] s;
      s = SUM_BITS'(a) + SUM_BITS'(b);
      return (s > SUM_BITS'(CURSOR_MAX)) ? CURSOR_MAX : CURSOR_BITS'(s);
   endfunction

endpackage

[rtl/bglq_div.sv]
// Serial restoring divider, one quotient bit per cycle, for the glyph scale factors.
// Depends on bglq_pkg.
module bglq_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [bglq_pkg::DIV_BITS-1:0]    dividend,
   input  logic [bglq_pkg::REG_BITS-1:0]    divisor,
   output logic [bglq_pkg::DIV_BITS-1:0]    quotient,
   output bglq_pkg::div_status_type         status
);

   localparam int CNT_BITS = $clog2(bglq_pkg::DIV_BITS + 1);

   logic [bglq_pkg::DIV_BITS-1:0] quo_ff, quo_in;
   logic [bglq_pkg::REG_BITS-1:0] rem_ff, rem_in;
   logic [bglq_pkg::REG_BITS-1:0] dvs_ff, dvs_in;
   logic [CNT_BITS-1:0]           cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;

   logic [bglq_pkg::REG_BITS:0] trial;
   logic [bglq_pkg::REG_BITS:0] diff;
   logic                        ge;

   always_comb begin
      trial = {rem_ff, quo_ff[bglq_pkg::DIV_BITS-1]};
      diff  = trial - {1'b0, dvs_ff};
      ge    = (trial >= {1'b0, dvs_ff});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_BITS'(bglq_pkg::DIV_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[bglq_pkg::REG_BITS-1:0] : trial[bglq_pkg::REG_BITS-1:0];
         quo_in = {quo_ff[bglq_pkg::DIV_BITS-2:0], ge};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

[rtl/bglq_emit.sv]
// Vertex output stage: holds one glyph quad and sends its four corners in order.
// Depends on bglq_pkg.
module bglq_emit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  bglq_pkg::vertex_set_type             set,
   output logic                                 busy,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // screen_x, screen_y, tex_u, tex_v, zero fill
   output logic [bglq_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // corner
   output logic [1:0]                           rsp_tuser,
   output logic                                 rsp_tlast
);

   bglq_pkg::vertex_set_type set_ff, set_in;
   bglq_pkg::corner_type     corner_ff, corner_in;
   logic                     busy_ff, busy_in;

   logic [bglq_pkg::X_BITS-1:0] x;
   logic [bglq_pkg::Y_BITS-1:0] y;
   logic [bglq_pkg::U_BITS-1:0] u;
   logic [bglq_pkg::V_BITS-1:0] v;

   always_comb begin
      set_in    = set_ff;
      corner_in = corner_ff;
      busy_in   = busy_ff;
      if (load) begin
         set_in    = set;
         corner_in = bglq_pkg::CORNER_TL;
         busy_in   = 1'b1;
      end else if (busy_ff && rsp_tready) begin
         unique case (corner_ff)
            bglq_pkg::CORNER_TL: corner_in = bglq_pkg::CORNER_TR;
            bglq_pkg::CORNER_TR: corner_in = bglq_pkg::CORNER_BR;
            bglq_pkg::CORNER_BR: corner_in = bglq_pkg::CORNER_BL;
            bglq_pkg::CORNER_BL: begin
               corner_in = bglq_pkg::CORNER_TL;
               busy_in   = 1'b0;
            end
            default: corner_in = bglq_pkg::CORNER_TL;
         endcase
      end
   end

   always_comb begin
      unique case (corner_ff)
         bglq_pkg::CORNER_TL: begin
            x = set_ff.x1; y = set_ff.y1; u = set_ff.u1; v = set_ff.v1;
         end
         bglq_pkg::CORNER_TR: begin
            x = set_ff.x2; y = set_ff.y1; u = set_ff.u2; v = set_ff.v1;
         end
         bglq_pkg::CORNER_BR: begin
            x = set_ff.x2; y = set_ff.y2; u = set_ff.u2; v = set_ff.v2;
         end
         default: begin
            x = set_ff.x1; y = set_ff.y2; u = set_ff.u1; v = set_ff.v2;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      set_ff <= set_in;
      if (reset) begin
         corner_ff <= bglq_pkg::CORNER_TL;
         busy_ff   <= 1'b0;
      end else begin
         corner_ff <= corner_in;
         busy_ff   <= busy_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = bglq_pkg::RSP_DATA_BITS'({v, u, y, x});
   assign rsp_tuser  = corner_ff;
   assign rsp_tlast  = (corner_ff == bglq_pkg::CORNER_BL);

endmodule

[rtl/bitmap_glyph_quad_layout.sv]
// Glyph quad layout: whitespace updates the cursor in its acceptance cycle, one per cycle
// while idle. A glyph runs MUL, DIV, DIV, three MUL steps and a load that waits while the
// emitter is busy; the first vertex is valid in the cycle the block returns to idle and the
// next character is taken with it. Both divisions use the one shared serial divider; no new
// character is taken until the glyph is loaded. Corners leave in order as rsp_tready allows.
// Reset is synchronous: cursor to origin, registers to defaults. Uses bglq_div, bglq_emit.
module bitmap_glyph_quad_layout (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // char_code, zero fill
   input  logic [bglq_pkg::REQ_DATA_BITS-1:0]       req_tdata,
   input  logic                                     req_tlast,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // screen_x, screen_y, tex_u, tex_v, zero fill
   output logic [bglq_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   // corner
   output logic [1:0]                               rsp_tuser,
   output logic                                     rsp_tlast,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [bglq_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [bglq_pkg::CSR_DATA_BITS-1:0]       csr_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_MUL_W, S_DIV_W, S_WAIT_W, S_DIV_C, S_WAIT_C,
      S_MUL_X, S_MUL_V, S_MUL_U, S_LOAD
   } state_type;

   localparam int CB = bglq_pkg::CURSOR_BITS;
   localparam int RB = bglq_pkg::REG_BITS;

   state_type state_ff, state_in;

   logic [RB-1:0] gw_ff, gw_in, gh_ff, gh_in, cap_ff, cap_in, cs_ff, cs_in, tab_ff, tab_in;
   logic [CB-1:0] col_ff, col_in, row_ff, row_in;

   logic [bglq_pkg::CODE_BITS-1:0] code_ff, code_in;
   logic                           last_ff, last_in;
   logic [bglq_pkg::PROD_BITS-1:0] prod_ff, prod_in;
   logic [bglq_pkg::DIV_BITS-1:0]  cellw_ff, cellw_in, capoff_ff, capoff_in;
   logic [bglq_pkg::Y_BITS-1:0]    y0_ff, y0_in;
   logic [bglq_pkg::X_BITS-1:0]    x1_ff, x1_in;
   logic [bglq_pkg::V_BITS-1:0]    v1_ff, v1_in;

   logic [bglq_pkg::MUL_A_BITS-1:0] mul_a;
   logic [bglq_pkg::MUL_B_BITS-1:0] mul_b;

   logic                           div_start;
   logic [bglq_pkg::DIV_BITS-1:0]  div_dividend;
   logic [RB-1:0]                  gh_eff;
   logic [bglq_pkg::DIV_BITS-1:0]  div_quotient;
   bglq_pkg::div_status_type       div_status;

   logic                     emit_load;
   logic                     emit_busy;
   bglq_pkg::vertex_set_type vset;

   logic [bglq_pkg::CODE_BITS-1:0] req_code;
   logic [RB:0]                    cell_rows;
   logic [bglq_pkg::U_BITS-1:0]    u1;
   logic                           req_fire;

   bglq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (gh_eff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   bglq_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (emit_load),
      .set        (vset),
      .busy       (emit_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign req_code   = req_tdata[bglq_pkg::CODE_BITS-1:0];
   assign req_fire   = req_tvalid && req_tready;
   assign gh_eff     = (gh_ff == '0) ? RB'(1) : gh_ff;
   assign cell_rows  = {1'b0, gh_ff} + {1'b0, cap_ff};
   assign div_dividend = {prod_ff[2*RB-1:0], {bglq_pkg::FRAC_BITS{1'b0}}};
   assign u1         = bglq_pkg::U_BITS'(prod_ff);

   always_comb begin
      vset.x1 = x1_ff;
      vset.x2 = x1_ff + bglq_pkg::X_BITS'(cellw_ff);
      vset.y1 = y0_ff - bglq_pkg::Y_BITS'(capoff_ff);
      vset.y2 = y0_ff + (bglq_pkg::Y_BITS'(cs_ff) << bglq_pkg::FRAC_BITS);
      vset.u1 = u1;
      vset.u2 = u1 + bglq_pkg::U_BITS'(gw_ff);
      vset.v1 = v1_ff;
      vset.v2 = v1_ff + bglq_pkg::V_BITS'(cell_rows);
   end

   always_comb begin
      state_in  = state_ff;
      gw_in     = gw_ff;
      gh_in     = gh_ff;
      cap_in    = cap_ff;
      cs_in     = cs_ff;
      tab_in    = tab_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      code_in   = code_ff;
      last_in   = last_ff;
      cellw_in  = cellw_ff;
      capoff_in = capoff_ff;
      y0_in     = y0_ff;
      x1_in     = x1_ff;
      v1_in     = v1_ff;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      emit_load = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            bglq_pkg::REG_GLYPH_WIDTH:  gw_in  = csr_data[RB-1:0];
            bglq_pkg::REG_GLYPH_HEIGHT: gh_in  = csr_data[RB-1:0];
            bglq_pkg::REG_CAP_TOP:      cap_in = csr_data[RB-1:0];
            bglq_pkg::REG_CHAR_SIZE:    cs_in  = csr_data[RB-1:0];
            bglq_pkg::REG_TAB_SIZE:     tab_in = csr_data[RB-1:0];
            // drop: color is applied downstream
            bglq_pkg::REG_FILL_COLOR:   ;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               code_in = req_code;
               last_in = req_tlast;
               if (req_code == bglq_pkg::CHAR_NEWLINE) begin
                  col_in = '0;
                  row_in = bglq_pkg::sat_add(row_ff, RB'(1));
               end else if (req_code == bglq_pkg::CHAR_TAB) begin
                  col_in = bglq_pkg::sat_add(col_ff, tab_ff);
               end else if (req_code == bglq_pkg::CHAR_SPACE ||
                            (req_code >= bglq_pkg::CHAR_VTAB &&
                             req_code <= bglq_pkg::CHAR_RETURN)) begin
                  col_in = bglq_pkg::sat_add(col_ff, RB'(1));
               end else begin
                  state_in = S_MUL_W;
               end
               if (req_tlast && !(state_in == S_MUL_W)) begin
                  col_in = '0;
                  row_in = '0;
               end
            end
         end
         S_MUL_W: begin
            mul_a    = bglq_pkg::MUL_A_BITS'(cs_ff);
            mul_b    = bglq_pkg::MUL_B_BITS'(gw_ff);
            state_in = S_DIV_W;
         end
         S_DIV_W: begin
            div_start = 1'b1;
            mul_a     = bglq_pkg::MUL_A_BITS'(cap_ff);
            mul_b     = bglq_pkg::MUL_B_BITS'(cs_ff);
            state_in  = S_WAIT_W;
         end
         S_WAIT_W: begin
            mul_a = bglq_pkg::MUL_A_BITS'(cap_ff);
            mul_b = bglq_pkg::MUL_B_BITS'(cs_ff);
            if (div_status.done) begin
               cellw_in = div_quotient;
               state_in = S_DIV_C;
            end
         end
         S_DIV_C: begin
            div_start = 1'b1;
            mul_a     = bglq_pkg::MUL_A_BITS'(cs_ff);
            mul_b     = bglq_pkg::MUL_B_BITS'(row_ff);
            state_in  = S_WAIT_C;
         end
         S_WAIT_C: begin
            mul_a = bglq_pkg::MUL_A_BITS'(cs_ff);
            mul_b = bglq_pkg::MUL_B_BITS'(row_ff);
            if (div_status.done) begin
               capoff_in = div_quotient;
               y0_in     = bglq_pkg::Y_BITS'(prod_ff) << bglq_pkg::FRAC_BITS;
               state_in  = S_MUL_X;
            end
         end
         S_MUL_X: begin
            mul_a    = cellw_ff;
            mul_b    = bglq_pkg::MUL_B_BITS'(col_ff);
            state_in = S_MUL_V;
         end
         S_MUL_V: begin
            x1_in    = bglq_pkg::X_BITS'(prod_ff);
            mul_a    = bglq_pkg::MUL_A_BITS'(cell_rows);
            mul_b    = code_ff[bglq_pkg::CODE_BITS-1:bglq_pkg::ATLAS_BITS];
            state_in = S_MUL_U;
         end
         S_MUL_U: begin
            v1_in    = bglq_pkg::V_BITS'(prod_ff);
            mul_a    = bglq_pkg::MUL_A_BITS'(gw_ff);
            mul_b    = bglq_pkg::MUL_B_BITS'(code_ff[bglq_pkg::ATLAS_BITS-1:0]);
            state_in = S_LOAD;
         end
         S_LOAD: begin
            mul_a = bglq_pkg::MUL_A_BITS'(gw_ff);
            mul_b = bglq_pkg::MUL_B_BITS'(code_ff[bglq_pkg::ATLAS_BITS-1:0]);
            if (!emit_busy) begin
               emit_load = 1'b1;
               col_in    = bglq_pkg::sat_add(col_ff, RB'(1));
               if (last_ff) begin
                  col_in = '0;
                  row_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      prod_in = bglq_pkg::PROD_BITS'(mul_a) * bglq_pkg::PROD_BITS'(mul_b);
   end

   always_ff @(posedge clock) begin
      code_ff   <= code_in;
      last_ff   <= last_in;
      prod_ff   <= prod_in;
      cellw_ff  <= cellw_in;
      capoff_ff <= capoff_in;
      y0_ff     <= y0_in;
      x1_ff     <= x1_in;
      v1_ff     <= v1_in;
      if (reset) begin
         state_ff <= S_IDLE;
         gw_ff    <= RB'(8);
         gh_ff    <= RB'(8);
         cap_ff   <= '0;
         cs_ff    <= RB'(8);
         tab_ff   <= RB'(4);
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         gw_ff    <= gw_in;
         gh_ff    <= gh_in;
         cap_ff   <= cap_in;
         cs_ff    <= cs_in;
         tab_ff   <= tab_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

`ifndef SYNTH
   a_div_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> (state_ff == S_WAIT_W || state_ff == S_WAIT_C))
      else $error("divider busy outside a wait state");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      emit_load |-> !rsp_tvalid)
      else $error("quad loaded over undelivered vertices");

   a_quad_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> !rsp_tvalid)
      else $error("vertex after quad end without a new load");
`endif

endmodule
